/* rtl/core/jsu_pkg.sv */
// ============================================================================
// jsu_pkg
// Shared types and constants of the JSON string unescaper: the command that
// the parser hands to the byte expander through the command queue.
// ============================================================================
`default_nettype none

package jsu_pkg;

  localparam int unsigned CAP_W = 16;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // Kind of the main segment of a command.
  typedef enum logic [1:0] {
    MAIN_NONE = 2'd0,
    MAIN_RAW  = 2'd1,
    MAIN_CP   = 2'd2
  } main_kind_t;

  // One parsed input byte. Segments are expanded in field order:
  // first surrogate flush, literal escape text, main byte or code point,
  // second surrogate flush, end marker.
  typedef struct packed {
    logic        hi_a_vld;
    logic [9:0]  hi_a_bits;
    logic        lit_vld;
    logic [1:0]  lit_n;
    logic [23:0] lit_digits;
    main_kind_t  main_kind;
    logic [20:0] main_val;
    logic        hi_b_vld;
    logic [9:0]  hi_b_bits;
    logic        eos;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/jsu_front.sv */
// ============================================================================
// jsu_front
// Escape parser: takes one raw byte per cycle while the command queue has room
// and turns it into at most one command for the byte expander.
// ============================================================================
`default_nettype none

module jsu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_last,
  input  wire logic           q_full,
  output logic                q_push,
  output jsu_pkg::cmd_t       q_cmd
);

  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_ESC   = 3'b010,
    PH_HEX   = 3'b100
  } phase_t;

  localparam logic [7:0] CH_N  = 8'h6E;
  localparam logic [7:0] CH_T  = 8'h74;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_B  = 8'h62;
  localparam logic [7:0] CH_F  = 8'h66;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [11:0] hex_r, hex_nxt;
  logic [23:0] held_r, held_nxt;
  logic        pend_r, pend_nxt;
  logic [9:0]  hbits_r, hbits_nxt;

  logic          accept;
  logic          plain;
  logic [4:0]    hex_d;
  logic [15:0]   hv;
  jsu_pkg::cmd_t cmd;

  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    begin
      r = '0;
      if (ch inside {[8'h30:8'h39]}) begin
        r = {1'b1, ch[3:0]};
      end else if ((ch inside {[8'h61:8'h66]}) || (ch inside {[8'h41:8'h46]})) begin
        r = {1'b1, ch[3:0] + 4'd9};
      end
      return r;
    end
  endfunction

  function automatic logic [7:0] simple_esc(input logic [7:0] ch);
    logic [7:0] r;
    begin
      case (ch)
        CH_N:    r = 8'h0A;
        CH_T:    r = 8'h09;
        CH_R:    r = 8'h0D;
        CH_B:    r = 8'h08;
        CH_F:    r = 8'h0C;
        default: r = ch;
      endcase
      return r;
    end
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hex_d    = hex_decode(in_byte);
  assign hv       = {hex_r, hex_d[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    hex_nxt   = hex_r;
    held_nxt  = held_r;
    pend_nxt  = pend_r;
    hbits_nxt = hbits_r;
    cmd       = '0;
    plain     = 1'b0;

    case (phase_r)
      PH_ESC: begin
        if (pend_r && (in_byte != jsu_pkg::CH_U)) begin
          cmd.hi_a_vld  = 1'b1;
          cmd.hi_a_bits = hbits_r;
          pend_nxt      = 1'b0;
        end
        if (in_byte == jsu_pkg::CH_U) begin
          phase_nxt = PH_HEX;
          cnt_nxt   = 2'd0;
          hex_nxt   = '0;
          held_nxt  = '0;
        end else begin
          cmd.main_kind = jsu_pkg::MAIN_RAW;
          cmd.main_val  = {13'd0, simple_esc(in_byte)};
          phase_nxt     = PH_PLAIN;
        end
      end
      PH_HEX: begin
        if (!hex_d[4]) begin
          // Bad digit: the escape goes out literally and the byte is
          // parsed again as plain text.
          if (pend_r) begin
            cmd.hi_a_vld  = 1'b1;
            cmd.hi_a_bits = hbits_r;
            pend_nxt      = 1'b0;
          end
          cmd.lit_vld    = 1'b1;
          cmd.lit_n      = cnt_r;
          cmd.lit_digits = held_r;
          held_nxt       = '0;
          hex_nxt        = '0;
          plain          = 1'b1;
        end else if (cnt_r != 2'd3) begin
          hex_nxt  = hv[11:0];
          held_nxt = {held_r[15:0], in_byte};
          cnt_nxt  = cnt_r + 2'd1;
        end else begin
          phase_nxt = PH_PLAIN;
          held_nxt  = '0;
          hex_nxt   = '0;
          cnt_nxt   = 2'd0;
          if (pend_r && (hv inside {[16'hDC00:16'hDFFF]})) begin
            cmd.main_kind = jsu_pkg::MAIN_CP;
            cmd.main_val  = 21'h10000 + {1'b0, hbits_r, hv[9:0]};
            pend_nxt      = 1'b0;
          end else begin
            if (pend_r) begin
              cmd.hi_a_vld  = 1'b1;
              cmd.hi_a_bits = hbits_r;
              pend_nxt      = 1'b0;
            end
            if (hv inside {[16'hD800:16'hDBFF]}) begin
              pend_nxt  = 1'b1;
              hbits_nxt = hv[9:0];
            end else begin
              cmd.main_kind = jsu_pkg::MAIN_CP;
              cmd.main_val  = {5'd0, hv};
            end
          end
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    if (plain) begin
      phase_nxt = PH_PLAIN;
      cnt_nxt   = 2'd0;
      if (pend_nxt && (in_byte != jsu_pkg::CH_BSLASH)) begin
        cmd.hi_a_vld  = 1'b1;
        cmd.hi_a_bits = hbits_r;
        pend_nxt      = 1'b0;
      end
      if (in_byte == jsu_pkg::CH_BSLASH) begin
        phase_nxt = PH_ESC;
      end else begin
        cmd.main_kind = jsu_pkg::MAIN_RAW;
        cmd.main_val  = {13'd0, in_byte};
      end
    end

    if (in_last) begin
      // Close out whatever the string left open, then return to plain text.
      if (pend_nxt) begin
        if (!cmd.hi_a_vld) begin
          cmd.hi_a_vld  = 1'b1;
          cmd.hi_a_bits = hbits_nxt;
        end else begin
          cmd.hi_b_vld  = 1'b1;
          cmd.hi_b_bits = hbits_nxt;
        end
      end
      if (phase_nxt == PH_ESC) begin
        cmd.main_kind = jsu_pkg::MAIN_RAW;
        cmd.main_val  = {13'd0, jsu_pkg::CH_BSLASH};
      end else if (phase_nxt == PH_HEX) begin
        cmd.lit_vld    = 1'b1;
        cmd.lit_n      = cnt_nxt;
        cmd.lit_digits = held_nxt;
      end
      cmd.eos   = 1'b1;
      phase_nxt = PH_PLAIN;
      cnt_nxt   = 2'd0;
      hex_nxt   = '0;
      held_nxt  = '0;
      pend_nxt  = 1'b0;
      hbits_nxt = '0;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd.hi_a_vld || cmd.lit_vld || cmd.hi_b_vld || cmd.eos ||
                             (cmd.main_kind != jsu_pkg::MAIN_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      cnt_r   <= '0;
      hex_r   <= '0;
      held_r  <= '0;
      pend_r  <= 1'b0;
      hbits_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      hex_r   <= hex_nxt;
      held_r  <= held_nxt;
      pend_r  <= pend_nxt;
      hbits_r <= hbits_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/jsu_cmd_fifo.sv */
// ============================================================================
// jsu_cmd_fifo
// Short command queue between the parser and the byte expander.
// ============================================================================
`default_nettype none

module jsu_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  jsu_pkg::cmd_t      wr_cmd,
  output logic               full,
  input  wire logic          pop,
  output jsu_pkg::cmd_t      head,
  output logic               head_vld
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  jsu_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign head_vld = (cnt_r != '0);
  assign head     = mem_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && head_vld;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_IDX) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_IDX) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/jsu_back.sv */
// ============================================================================
// jsu_back
// Byte expander: walks the head command's segments one byte per cycle unless
// the output stalls, applies the capacity limit, drives the output register.
// ============================================================================
`default_nettype none

module jsu_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [jsu_pkg::CAP_W-1:0]  cap,
  input  jsu_pkg::cmd_t                   head,
  input  wire logic                       head_vld,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_has_byte,
  output logic                            out_end_of_string,
  output logic                            out_dropped
);

  typedef enum logic [4:0] {
    SEG_HIA  = 5'b00001,
    SEG_LIT  = 5'b00010,
    SEG_MAIN = 5'b00100,
    SEG_HIB  = 5'b01000,
    SEG_END  = 5'b10000
  } seg_t;

  logic [4:0]                mask_r, mask_nxt;
  logic                      live_r, live_nxt;
  logic [2:0]                sub_r, sub_nxt;
  logic [jsu_pkg::CAP_W-1:0] bw_r, bw_nxt;
  logic                      drop_r, drop_nxt;

  logic                      out_vld_r, out_vld_nxt;
  logic [7:0]                out_byte_r, out_byte_nxt;
  logic                      out_has_r, out_has_nxt;
  logic                      out_eos_r, out_eos_nxt;
  logic                      out_trunc_r, out_trunc_nxt;

  logic [4:0] head_mask;
  logic [4:0] eff;
  logic [4:0] cur_bits;
  logic [4:0] mask_after;
  seg_t       cur;
  logic [2:0] seg_len;
  logic [7:0] seg_byte;
  logic       last_byte;
  logic       go;
  logic       is_end;
  logic       fits;
  logic       wr;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] r;
    begin
      if (cp < 21'h80) begin
        r = 3'd1;
      end else if (cp < 21'h800) begin
        r = 3'd2;
      end else if (cp < 21'h10000) begin
        r = 3'd3;
      end else begin
        r = 3'd4;
      end
      return r;
    end
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] k);
    logic [2:0] n;
    logic [7:0] r;
    begin
      n = utf8_len(cp);
      r = cp[7:0];
      case (n)
        3'd2: r = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        3'd3: begin
          case (k)
            2'd0:    r = {4'b1110, cp[15:12]};
            2'd1:    r = {2'b10, cp[11:6]};
            default: r = {2'b10, cp[5:0]};
          endcase
        end
        3'd4: begin
          case (k)
            2'd0:    r = {5'b11110, cp[20:18]};
            2'd1:    r = {2'b10, cp[17:12]};
            2'd2:    r = {2'b10, cp[11:6]};
            default: r = {2'b10, cp[5:0]};
          endcase
        end
        default: r = cp[7:0];
      endcase
      return r;
    end
  endfunction

  // Three-byte form of a lone surrogate 0xD800 + bits.
  function automatic logic [7:0] surr_byte(input logic [9:0] bits, input logic [1:0] k);
    logic [7:0] r;
    begin
      case (k)
        2'd0:    r = 8'hED;
        2'd1:    r = {4'hA, bits[9:6]};
        default: r = {2'b10, bits[5:0]};
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] lit_byte(input logic [1:0] n, input logic [23:0] digits,
                                          input logic [2:0] k);
    logic [2:0] sel;
    logic [7:0] r;
    begin
      sel = {1'b0, n} + 3'd1 - k;
      if (k == 3'd0) begin
        r = jsu_pkg::CH_BSLASH;
      end else if (k == 3'd1) begin
        r = jsu_pkg::CH_U;
      end else begin
        case (sel[1:0])
          2'd0:    r = digits[7:0];
          2'd1:    r = digits[15:8];
          default: r = digits[23:16];
        endcase
      end
      return r;
    end
  endfunction

  assign head_mask = head_vld ? {head.eos, head.hi_b_vld,
                                 (head.main_kind != jsu_pkg::MAIN_NONE),
                                 head.lit_vld, head.hi_a_vld} : 5'd0;
  assign eff       = live_r ? mask_r : head_mask;
  assign cur_bits  = eff & (~eff + 5'd1);
  assign cur       = seg_t'(cur_bits);

  always_comb begin
    case (cur)
      SEG_HIA: begin
        seg_len  = 3'd3;
        seg_byte = surr_byte(head.hi_a_bits, sub_r[1:0]);
      end
      SEG_LIT: begin
        seg_len  = 3'd2 + {1'b0, head.lit_n};
        seg_byte = lit_byte(head.lit_n, head.lit_digits, sub_r);
      end
      SEG_MAIN: begin
        if (head.main_kind == jsu_pkg::MAIN_CP) begin
          seg_len  = utf8_len(head.main_val);
          seg_byte = utf8_byte(head.main_val, sub_r[1:0]);
        end else begin
          seg_len  = 3'd1;
          seg_byte = head.main_val[7:0];
        end
      end
      SEG_HIB: begin
        seg_len  = 3'd3;
        seg_byte = surr_byte(head.hi_b_bits, sub_r[1:0]);
      end
      default: begin
        seg_len  = 3'd1;
        seg_byte = 8'd0;
      end
    endcase
  end

  assign last_byte  = (sub_r == (seg_len - 3'd1));
  assign go         = head_vld && (!out_vld_r || out_ready);
  assign is_end     = (cur == SEG_END);
  assign fits       = (({1'b0, bw_r} + 17'd1) < {1'b0, cap});
  assign wr         = is_end || fits;
  assign mask_after = eff & ~cur_bits;
  assign pop        = go && last_byte && (mask_after == 5'd0);

  always_comb begin
    mask_nxt      = mask_r;
    live_nxt      = live_r;
    sub_nxt       = sub_r;
    bw_nxt        = bw_r;
    drop_nxt      = drop_r;
    out_vld_nxt   = out_vld_r;
    out_byte_nxt  = out_byte_r;
    out_has_nxt   = out_has_r;
    out_eos_nxt   = out_eos_r;
    out_trunc_nxt = out_trunc_r;

    if (go) begin
      out_vld_nxt = wr;
      if (wr) begin
        out_byte_nxt  = is_end ? 8'd0 : seg_byte;
        out_has_nxt   = !is_end;
        out_eos_nxt   = is_end;
        out_trunc_nxt = is_end && drop_r;
      end
      if (is_end) begin
        bw_nxt   = '0;
        drop_nxt = 1'b0;
      end else if (fits) begin
        bw_nxt = bw_r + 16'd1;
      end else begin
        drop_nxt = 1'b1;
      end
      if (last_byte) begin
        sub_nxt  = '0;
        mask_nxt = mask_after;
        live_nxt = (mask_after != 5'd0);
      end else begin
        sub_nxt  = sub_r + 3'd1;
        mask_nxt = eff;
        live_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      live_r    <= 1'b0;
      sub_r     <= '0;
      bw_r      <= '0;
      drop_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      mask_r    <= mask_nxt;
      live_r    <= live_nxt;
      sub_r     <= sub_nxt;
      bw_r      <= bw_nxt;
      drop_r    <= drop_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_has_r   <= out_has_nxt;
    out_eos_r   <= out_eos_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_byte          = out_byte_r;
  assign out_has_byte      = out_has_r;
  assign out_end_of_string = out_eos_r;
  assign out_dropped       = out_trunc_r;

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && is_end) |=> ((bw_r == '0) && !drop_r))
    else $error("byte count or drop flag not cleared after end marker");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !is_end && fits) |=> (bw_r == ($past(bw_r) + 16'd1)))
    else $error("byte count did not advance on a written data byte");

  a_drop_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !is_end && !fits) |=> (!out_vld_r && drop_r))
    else $error("dropped byte reached the output register");

  a_live_seg: assert property (@(posedge clk) disable iff (!rst_n)
    live_r |-> ((mask_r != 5'd0) && (sub_r < seg_len)))
    else $error("expander position outside the current segment");

endmodule

`default_nettype wire

/* rtl/core/json_string_unescape_utf8.sv */
// ============================================================================
// json_string_unescape_utf8
// Path: the parser writes the command queue at the edge that accepts an input
//   byte, and the expander loads each result from the queue head into its
//   output register.
// Throughput: one input byte per cycle while the command queue has room; the
//   expander takes decoded bytes one at a time, dropped bytes and the end marker
//   included, so a byte that expands into a multi-byte result holds it longer.
// Reset: synchronous, active low; clears parser, queue and counters and sets
//   the capacity register cap_r to 256.
//
// Streaming unescaper for the body of a JSON string. The parser handles the
// simple escapes, gathers \uXXXX digits, pairs high and low surrogates and
// decides what text must be flushed literally (bad digits, a string that
// ends inside an escape). It writes at most one command per input byte into a
// short queue. The expander turns each command into UTF-8 bytes, enforces the
// output capacity (capacity minus one data bytes per string) and closes each
// string with an end marker that reports whether bytes were dropped.
// ============================================================================
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_end_of_string,
  output logic             out_dropped
);

  localparam logic [jsu_pkg::CAP_W-1:0] CAP_RESET = 16'd256;

  // Output capacity in bytes, terminator included. The user must write it only
  // while the block is idle; the block does not enforce it, so a plain register serves.
  logic [jsu_pkg::CAP_W-1:0] cap_r, cap_nxt;

  // Queue signals between the parser and the expander.
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_head_vld;
  jsu_pkg::cmd_t q_wr_cmd;
  jsu_pkg::cmd_t q_head;

  assign cap_nxt = cfg_wr_en ? cfg_wr_data : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // The parser accepts a byte whenever the queue has room, independent of
  // how busy the expander is; bytes that produce nothing push no command.
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_wr_cmd)
  );

  // The queue absorbs the bursts of a byte that expands into several
  // results, such as a surrogate pair or a flushed literal escape.
  jsu_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_cmd   (q_wr_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .head_vld (q_head_vld)
  );

  // The expander works on the queue head in place and pops it after its
  // last segment; its output register lets it move on as soon as the
  // current result is taken.
  jsu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cap               (cap_r),
    .head              (q_head),
    .head_vld          (q_head_vld),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_has_byte      (out_has_byte),
    .out_end_of_string (out_end_of_string),
    .out_dropped       (out_dropped)
  );

endmodule

`default_nettype wire
